>>> src/hsv_to_rgb_convert_assert.svh
// Assertion macros for the HSV to RGB converter.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef HSV_TO_RGB_CONVERT_ASSERT_SVH
`define HSV_TO_RGB_CONVERT_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define HSV_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold after the antecedent, delayed by the LATENCY parameter of the using module.
`define HSV_ASSERT_DELAY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##LATENCY (cons)) \
    else $error(msg);

`else

`define HSV_ASSERT_IMPLY(lbl, ante, cons, msg)
`define HSV_ASSERT_DELAY(lbl, ante, cons, msg)

`endif

`endif

>>> src/hsv_pkg.sv
package hsv_pkg;

  localparam int HUE_W   = 9;
  localparam int CH_W    = 8;
  localparam int FRAC_W  = 6;
  localparam int PROD_W  = 14;
  localparam int PNUM_W  = 16;
  localparam int QNUM_W  = 22;

  localparam int SECTOR_DEG = 60;
  localparam int FULL_TURN  = 360;
  localparam int SAT_ONE    = 255;
  localparam int QT_DEN     = SAT_ONE * SECTOR_DEG;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // Per-pixel data that rides along the pipeline next to the arithmetic.
  typedef struct packed {
    sector_t          sector;
    logic [CH_W-1:0]  v;
  } pix_t;

endpackage

>>> src/hsv_sector.sv
module hsv_sector (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [hsv_pkg::HUE_W-1:0] hue_deg,
  input  logic [hsv_pkg::CH_W-1:0]  saturation,
  input  logic [hsv_pkg::CH_W-1:0]  brightness,
  output logic                      out_valid,
  output hsv_pkg::pix_t             pix,
  output logic [hsv_pkg::FRAC_W-1:0] frac,
  output logic [hsv_pkg::CH_W-1:0]  sat
);
  import hsv_pkg::*;

  logic [HUE_W-1:0]  hue_w;
  sector_t           sector_next;
  logic [HUE_W-1:0]  base;

  // Hues from 360 up wrap once, then a compare chain finds the sector.
  always_comb begin
    hue_w = (hue_deg >= HUE_W'(FULL_TURN)) ? hue_deg - HUE_W'(FULL_TURN) : hue_deg;
    priority if (hue_w >= HUE_W'(5 * SECTOR_DEG)) begin
      sector_next = SEC_MAG_RED;
      base        = HUE_W'(5 * SECTOR_DEG);
    end else if (hue_w >= HUE_W'(4 * SECTOR_DEG)) begin
      sector_next = SEC_BLU_MAG;
      base        = HUE_W'(4 * SECTOR_DEG);
    end else if (hue_w >= HUE_W'(3 * SECTOR_DEG)) begin
      sector_next = SEC_CYN_BLU;
      base        = HUE_W'(3 * SECTOR_DEG);
    end else if (hue_w >= HUE_W'(2 * SECTOR_DEG)) begin
      sector_next = SEC_GRN_CYN;
      base        = HUE_W'(2 * SECTOR_DEG);
    end else if (hue_w >= HUE_W'(SECTOR_DEG)) begin
      sector_next = SEC_YEL_GRN;
      base        = HUE_W'(SECTOR_DEG);
    end else begin
      sector_next = SEC_RED_YEL;
      base        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    pix.sector <= sector_next;
    pix.v      <= brightness;
    frac       <= FRAC_W'(hue_w - base);
    sat        <= saturation;
  end

endmodule

>>> src/hsv_levels.sv
module hsv_levels (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  hsv_pkg::pix_t               in_pix,
  input  logic [hsv_pkg::FRAC_W-1:0]  frac,
  input  logic [hsv_pkg::CH_W-1:0]    sat,
  output logic                        out_valid,
  output hsv_pkg::pix_t               out_pix,
  output logic [hsv_pkg::PNUM_W-1:0]  p_num,
  output logic [hsv_pkg::QNUM_W-1:0]  q_num,
  output logic [hsv_pkg::QNUM_W-1:0]  t_num
);
  import hsv_pkg::*;

  // First stage: saturation products and the p numerator.
  logic                valid_a;
  pix_t                pix_a;
  logic [PROD_W-1:0]   sf_a;
  logic [PROD_W-1:0]   st_a;
  logic [PNUM_W-1:0]   pn_a;
  logic [FRAC_W-1:0]   rest;

  assign rest = FRAC_W'(SECTOR_DEG) - frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_a   <= in_valid;
      out_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    pix_a <= in_pix;
    sf_a  <= PROD_W'(sat) * PROD_W'(frac);
    st_a  <= PROD_W'(sat) * PROD_W'(rest);
    pn_a  <= PNUM_W'(in_pix.v) * PNUM_W'(CH_W'(SAT_ONE) - sat);
  end

  // Second stage: brightness times the q and t weights.
  always_ff @(posedge clk) begin
    out_pix <= pix_a;
    p_num   <= pn_a;
    q_num   <= QNUM_W'(pix_a.v) * QNUM_W'(PROD_W'(QT_DEN) - sf_a);
    t_num   <= QNUM_W'(pix_a.v) * QNUM_W'(PROD_W'(QT_DEN) - st_a);
  end

endmodule

>>> src/hsv_rdiv.sv
// Rounded division by a constant, floor((2x + d) / 2d), in two stages:
// a reciprocal estimate that is low by at most one, then one correction.
module hsv_rdiv #(
  parameter int unsigned DEN   = 255,
  parameter int          NUM_W = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [NUM_W-1:0]          num,
  output logic                      out_valid,
  output logic [hsv_pkg::CH_W-1:0]  quo
);
  import hsv_pkg::*;

  localparam int          K     = NUM_W + 1;
  localparam int unsigned DIV2  = 2 * DEN;
  localparam int unsigned MUL   = (2 ** K) / DIV2;
  localparam int          MUL_W = $clog2(MUL + 1);
  localparam int          PRD_W = K + MUL_W;

  logic [K-1:0]      n;
  logic [PRD_W-1:0]  prod;
  logic              valid_a;
  logic [K-1:0]      n_a;
  logic [CH_W-1:0]   est_a;
  logic [K-1:0]      rem;

  assign n    = {num, 1'b0} + K'(DEN);
  assign prod = PRD_W'(n) * PRD_W'(MUL_W'(MUL));
  assign rem  = n_a - K'(est_a) * K'(DIV2);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_a   <= in_valid;
      out_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    n_a   <= n;
    est_a <= prod[K +: CH_W];
    quo   <= (rem >= K'(DIV2)) ? est_a + CH_W'(1) : est_a;
  end

endmodule

>>> src/hsv_to_rgb_convert.sv
// HSV to RGB pixel converter, fixed point, six-sector rule.
//
// Input channel: hue_deg (0..359 degrees, 360..511 wraps by subtracting 360),
// saturation and brightness (8 bits, 255 is full scale). A transfer happens
// at each rising edge where start is high and busy is low. busy is always
// low: the pipeline takes a new pixel on every clock cycle.
//
// Output channel: red, green and blue are valid for exactly one cycle while
// done is high. There is no backpressure, so the receiver must take every
// transfer in the cycle it appears.
//
// Throughput is one pixel per cycle. The pipeline stages, from the accepting
// edge to the register that drives done, are: sector and fraction lookup,
// saturation products, brightness products, reciprocal quotient estimate,
// quotient correction, and channel selection.
//
// A synchronous reset clears all valid bits, so done stays low until new
// pixels have passed through the pipeline. Data registers are not reset.
`include "hsv_to_rgb_convert_assert.svh"

module hsv_to_rgb_convert (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [hsv_pkg::HUE_W-1:0] hue_deg,
  input  logic [hsv_pkg::CH_W-1:0]  saturation,
  input  logic [hsv_pkg::CH_W-1:0]  brightness,
  output logic                      done,
  output logic [hsv_pkg::CH_W-1:0]  red,
  output logic [hsv_pkg::CH_W-1:0]  green,
  output logic [hsv_pkg::CH_W-1:0]  blue
);
  import hsv_pkg::*;

  localparam int LATENCY = 6;

  logic                s1_valid;
  pix_t                s1_pix;
  logic [FRAC_W-1:0]   s1_frac;
  logic [CH_W-1:0]     s1_sat;

  logic                s3_valid;
  pix_t                s3_pix;
  logic [PNUM_W-1:0]   s3_pnum;
  logic [QNUM_W-1:0]   s3_qnum;
  logic [QNUM_W-1:0]   s3_tnum;

  logic                p_valid;
  logic                q_valid;
  logic                t_valid;
  logic [CH_W-1:0]     p_lvl;
  logic [CH_W-1:0]     q_lvl;
  logic [CH_W-1:0]     t_lvl;

  // Sector and brightness wait here while the dividers work.
  pix_t                pix_d1;
  pix_t                pix_d2;

  logic [CH_W-1:0]     red_next;
  logic [CH_W-1:0]     green_next;
  logic [CH_W-1:0]     blue_next;
  logic [CH_W-1:0]     v_out;

  // Every stage advances each cycle, so the block is never busy.
  assign busy = 1'b0;

  hsv_sector u_sector (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start),
    .hue_deg    (hue_deg),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (s1_valid),
    .pix        (s1_pix),
    .frac       (s1_frac),
    .sat        (s1_sat)
  );

  hsv_levels u_levels (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_pix    (s1_pix),
    .frac      (s1_frac),
    .sat       (s1_sat),
    .out_valid (s3_valid),
    .out_pix   (s3_pix),
    .p_num     (s3_pnum),
    .q_num     (s3_qnum),
    .t_num     (s3_tnum)
  );

  // p divides by full saturation; q and t divide by full saturation times
  // the sector width.
  hsv_rdiv #(
    .DEN   (SAT_ONE),
    .NUM_W (PNUM_W)
  ) u_div_p (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .num       (s3_pnum),
    .out_valid (p_valid),
    .quo       (p_lvl)
  );

  hsv_rdiv #(
    .DEN   (QT_DEN),
    .NUM_W (QNUM_W)
  ) u_div_q (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .num       (s3_qnum),
    .out_valid (q_valid),
    .quo       (q_lvl)
  );

  hsv_rdiv #(
    .DEN   (QT_DEN),
    .NUM_W (QNUM_W)
  ) u_div_t (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .num       (s3_tnum),
    .out_valid (t_valid),
    .quo       (t_lvl)
  );

  always_ff @(posedge clk) begin
    pix_d1 <= s3_pix;
    pix_d2 <= pix_d1;
  end

  // Channel selection by sector. Zero saturation needs no special case:
  // all three levels then round to the brightness itself.
  always_comb begin
    unique case (pix_d2.sector)
      SEC_RED_YEL: begin
        red_next   = pix_d2.v;
        green_next = t_lvl;
        blue_next  = p_lvl;
      end
      SEC_YEL_GRN: begin
        red_next   = q_lvl;
        green_next = pix_d2.v;
        blue_next  = p_lvl;
      end
      SEC_GRN_CYN: begin
        red_next   = p_lvl;
        green_next = pix_d2.v;
        blue_next  = t_lvl;
      end
      SEC_CYN_BLU: begin
        red_next   = p_lvl;
        green_next = q_lvl;
        blue_next  = pix_d2.v;
      end
      SEC_BLU_MAG: begin
        red_next   = t_lvl;
        green_next = p_lvl;
        blue_next  = pix_d2.v;
      end
      default: begin
        red_next   = pix_d2.v;
        green_next = p_lvl;
        blue_next  = q_lvl;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p_valid & q_valid & t_valid;
    end
  end

  always_ff @(posedge clk) begin
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
    v_out <= pix_d2.v;
  end

  // Every accepted pixel comes out after the fixed pipeline latency.
  `HSV_ASSERT_DELAY(a_latency, start && !busy, done, "accepted pixel did not complete on time")

  // One channel always carries the brightness, and none exceeds it.
  `HSV_ASSERT_IMPLY(a_peak, done, red == v_out || green == v_out || blue == v_out, "peak missing")
  `HSV_ASSERT_IMPLY(a_bound, done, red <= v_out && green <= v_out && blue <= v_out, "level too high")

endmodule

>>> sim/tb_hsv_to_rgb_convert.sv
`timescale 1ns / 100ps

// Testbench for the HSV to RGB pixel converter.
//
// Pixels are driven on the falling edge and a transfer happens on the rising
// edge where start is high and busy is low. At that same edge the scoreboard
// computes the expected RGB triple from the HSV fields on the ports and queues
// it. Every cycle in which done is high, the oldest queued triple is compared
// field by field with red, green and blue. The converter has no backpressure
// on its output side, so only the sending side is throttled.
module tb_hsv_to_rgb_convert;
  import hsv_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 8;
  localparam int PIPE_LATENCY = 6;
  // Cycles without any transfer in either direction before the run is declared hung.
  localparam int STALL_LIMIT  = 500;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [HUE_W-1:0]  hue_deg;
  logic [CH_W-1:0]   saturation;
  logic [CH_W-1:0]   brightness;
  logic              done;
  logic [CH_W-1:0]   red;
  logic [CH_W-1:0]   green;
  logic [CH_W-1:0]   blue;

  // RGB triples still owed by the converter, oldest first.
  rgb_t rgb_pending[$];
  int   error_count = 0;
  int   quiet_cycles = 0;

  hsv_to_rgb_convert dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue_deg    (hue_deg),
    .saturation (saturation),
    .brightness (brightness),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Ratio num/den rounded half up, done in integers.
  function automatic int unsigned round_ratio(input int unsigned num, input int unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  // Expected converter output for one pixel. Hues from 360 up wrap back by a
  // full turn, and zero saturation short-circuits to grey.
  function automatic rgb_t convert_pixel(input logic [HUE_W-1:0] hue,
                                         input logic [CH_W-1:0] sat,
                                         input logic [CH_W-1:0] val);
    int unsigned h;
    int unsigned s;
    int unsigned v;
    int unsigned frac;
    int unsigned p;
    int unsigned q;
    int unsigned t;
    sector_t     sector;
    rgb_t        pix;
    h = 32'(hue);
    s = 32'(sat);
    v = 32'(val);
    if (h >= FULL_TURN) h = h - FULL_TURN;
    pix.red   = val;
    pix.green = val;
    pix.blue  = val;
    if (s != 0) begin
      sector = sector_t'(3'(h / SECTOR_DEG));
      frac   = h % SECTOR_DEG;
      p = round_ratio(v * (SAT_ONE - s), SAT_ONE);
      q = round_ratio(v * (QT_DEN - s * frac), QT_DEN);
      t = round_ratio(v * (QT_DEN - s * (SECTOR_DEG - frac)), QT_DEN);
      case (sector)
        SEC_RED_YEL: begin
          pix.green = t[CH_W-1:0];
          pix.blue  = p[CH_W-1:0];
        end
        SEC_YEL_GRN: begin
          pix.red   = q[CH_W-1:0];
          pix.blue  = p[CH_W-1:0];
        end
        SEC_GRN_CYN: begin
          pix.red   = p[CH_W-1:0];
          pix.blue  = t[CH_W-1:0];
        end
        SEC_CYN_BLU: begin
          pix.red   = p[CH_W-1:0];
          pix.green = q[CH_W-1:0];
        end
        SEC_BLU_MAG: begin
          pix.red   = t[CH_W-1:0];
          pix.green = p[CH_W-1:0];
        end
        default: begin
          pix.green = p[CH_W-1:0];
          pix.blue  = q[CH_W-1:0];
        end
      endcase
    end
    return pix;
  endfunction

  task automatic compare_channel(input string name, input logic [CH_W-1:0] want,
                                 input logic [CH_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Scoreboard and watchdog. Everything that happens at a rising edge is
  // handled in this one process, so a result leaving the converter and a new
  // pixel entering it on the same edge are always seen in a fixed order.
  always @(posedge clk) begin : scoreboard
    rgb_t want;
    if (!rst) begin
      if ($isunknown(done)) begin
        $error("done: expected 0 or 1, got %b", done);
        error_count++;
      end else if (done) begin
        if (rgb_pending.size() == 0) begin
          $error("unexpected result: red %0d, green %0d, blue %0d", red, green, blue);
          error_count++;
        end else begin
          want = rgb_pending.pop_front();
          compare_channel("red", want.red, red);
          compare_channel("green", want.green, green);
          compare_channel("blue", want.blue, blue);
        end
      end
      if (start && busy === 1'b0)
        rgb_pending = {rgb_pending, convert_pixel(hue_deg, saturation, brightness)};

      // Any transfer, in or out, counts as progress.
      if (done === 1'b1 || (start && busy === 1'b0)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_hsv_to_rgb_convert: done, errors");
        $finish;
      end
    end
  end

  // Present one pixel and hold it until the converter takes it. start is left
  // high so that back-to-back pixels need no gap.
  task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [CH_W-1:0] sat,
                            input logic [CH_W-1:0] val);
    @(negedge clk);
    start      <= 1'b1;
    hue_deg    <= hue;
    saturation <= sat;
    brightness <= val;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drop start for a number of cycles and put junk on the idle data ports.
  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start      <= 1'b0;
      hue_deg    <= HUE_W'($urandom);
      saturation <= CH_W'($urandom);
      brightness <= CH_W'($urandom);
    end
  endtask

  // Sampled on the falling edge so the check never races the scoreboard.
  task automatic wait_for_results();
    while (rgb_pending.size() != 0) @(negedge clk);
  endtask

  // Random pixel with extra weight on the wrapped hue range and on the
  // saturation and brightness extremes, followed by idle cycles, each one
  // taken with a chance of idle_pct percent.
  task automatic send_random_pixel(input int idle_pct);
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
    hue = ($urandom_range(9) == 0) ? HUE_W'($urandom_range(511, 360))
                                   : HUE_W'($urandom_range(359, 0));
    case ($urandom_range(15))
      0:       sat = '0;
      1:       sat = '1;
      2:       sat = 8'd1;
      default: sat = CH_W'($urandom);
    endcase
    case ($urandom_range(15))
      0:       val = '0;
      1:       val = '1;
      default: val = CH_W'($urandom);
    endcase
    send_pixel(hue, sat, val);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct)
      hold_off(1);
  endtask

  // Sector boundaries at full saturation, grey, black, wrapped hues and a few
  // values where the half-up rounding decides the last bit.
  task automatic test_corner_pixels();
    send_pixel(9'd0,   8'd255, 8'd255);
    send_pixel(9'd59,  8'd255, 8'd255);
    send_pixel(9'd60,  8'd255, 8'd255);
    send_pixel(9'd119, 8'd255, 8'd255);
    send_pixel(9'd120, 8'd255, 8'd255);
    send_pixel(9'd179, 8'd255, 8'd255);
    send_pixel(9'd180, 8'd255, 8'd255);
    send_pixel(9'd239, 8'd255, 8'd255);
    send_pixel(9'd240, 8'd255, 8'd255);
    send_pixel(9'd299, 8'd255, 8'd255);
    send_pixel(9'd300, 8'd255, 8'd255);
    send_pixel(9'd359, 8'd255, 8'd255);
    send_pixel(9'd200, 8'd0,   8'd137);
    send_pixel(9'd0,   8'd0,   8'd255);
    send_pixel(9'd90,  8'd255, 8'd0);
    send_pixel(9'd30,  8'd128, 8'd200);
    send_pixel(9'd360, 8'd255, 8'd255);
    send_pixel(9'd419, 8'd255, 8'd255);
    send_pixel(9'd511, 8'd200, 8'd100);
    send_pixel(9'd45,  8'd1,   8'd255);
    send_pixel(9'd15,  8'd254, 8'd1);
    send_pixel(9'd330, 8'd127, 8'd255);
    hold_off(1);
  endtask

  task automatic test_random_pixels(input int count, input int idle_pct);
    repeat (count) send_random_pixel(idle_pct);
    hold_off(1);
  endtask

  // Short bursts, each one followed by a full drain of the pipeline, so the
  // converter also runs from an empty pipeline several times.
  task automatic test_pause_and_drain();
    repeat (4) begin
      repeat ($urandom_range(15, 5)) send_random_pixel(0);
      hold_off(1);
      wait_for_results();
    end
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    hue_deg      = '0;
    saturation   = '0;
    brightness   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_corner_pixels();
    test_random_pixels(650, 18);
    test_random_pixels(650, 60);
    test_pause_and_drain();
    test_random_pixels(600, 0);

    // Let the last results come out, then watch a little longer for strays.
    wait_for_results();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_hsv_to_rgb_convert: done, clean");
    end else begin
      $display("tb_hsv_to_rgb_convert: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/hsv_pkg.sv
src/hsv_sector.sv
src/hsv_levels.sv
src/hsv_rdiv.sv
src/hsv_to_rgb_convert.sv
sim/tb_hsv_to_rgb_convert.sv
